// ----- hw/rtl/dcoc_pkg.sv -----
// ----------------------------------------------------------------------------
// dcoc_pkg
// shared types and constants of the digit code occurrence counter
// ----------------------------------------------------------------------------
`default_nettype none

package dcoc_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int MAX_DIGITS_DEF  = 16;

  localparam int KEY_W   = 64;
  localparam int LEN_W   = 5;
  localparam int COUNT_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_EMPTY = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [1:0] KIND_ENTRY   = 2'd0;
  localparam logic [1:0] KIND_INVALID = 2'd1;
  localparam logic [1:0] KIND_FULL    = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_MATCH,
    CELL_UPDATE,
    CELL_SHIFT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      any_hit;
    logic      full;
  } cell_ctrl_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [LEN_W-1:0]   len;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_DUMP
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dcoc_cell.sv -----
// ----------------------------------------------------------------------------
// dcoc_cell
// one table entry: compares against the finished code, counts a hit, takes a
// new code when it is the first free cell, and shifts toward the head on readout
// ----------------------------------------------------------------------------
`default_nettype none

module dcoc_cell
  import dcoc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cell_ctrl_t         ctrl,
  input  wire logic [KEY_W-1:0]   key_in,
  input  wire logic [LEN_W-1:0]   len_in,
  input  wire logic               prev_valid,
  input  wire entry_t             shift_in,
  output entry_t                  entry,
  output logic                    hit
);

  logic append;

  assign append = !entry.valid && prev_valid && !ctrl.any_hit && !ctrl.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
      hit         <= 1'b0;
    end else begin
      case (ctrl.cmd)
        CELL_MATCH: begin
          hit <= entry.valid && (entry.key == key_in) && (entry.len == len_in);
        end
        CELL_UPDATE: begin
          if (ctrl.any_hit) begin
            if (hit && (entry.count != COUNT_MAX)) begin
              entry.count <= entry.count + 1'b1;
            end
          end else if (append) begin
            entry.valid <= 1'b1;
            entry.key   <= key_in;
            entry.len   <= len_in;
            entry.count <= COUNT_W'(1);
          end
        end
        CELL_SHIFT: begin
          entry <= shift_in;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/digit_code_occurrence_counter.sv -----
// ----------------------------------------------------------------------------
// digit_code_occurrence_counter
// packs code digits as bcd and counts distinct codes in a chain of entry cells
// ----------------------------------------------------------------------------
// a digit word shifts its bcd digit into the code without going busy; a word that ends a code
// then runs a broadcast compare in every cell, then hit count or append at the first free cell
// end of input, with no open code and a filled head cell, streams one entry per cycle
// from the head of the chain, and busy stays high while the chain shifts out
// an invalid word reports in the cycle after it; table full reports after the update state
// synchronous reset clears the code, the cell valid bits and the halt flag
`default_nettype none

module digit_code_occurrence_counter
  import dcoc_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         opcode,
  input  wire logic [7:0]         char_value,
  input  wire logic               code_end,
  output logic                    valid,
  output logic [1:0]              kind,
  output logic [KEY_W-1:0]        code_bcd,
  output logic [LEN_W-1:0]        code_length,
  output logic [COUNT_W-1:0]      occurrences,
  output logic                    last_result
);

  state_t             state, state_next;
  logic [KEY_W-1:0]   cur_key, cur_key_next;
  logic [LEN_W-1:0]   cur_len, cur_len_next;
  logic               halted, halted_next;
  logic               valid_next;
  logic [1:0]         kind_next;
  logic [KEY_W-1:0]   code_bcd_next;
  logic [LEN_W-1:0]   code_length_next;
  logic [COUNT_W-1:0] occurrences_next;
  logic               last_result_next;

  cell_ctrl_t             ctrl;
  entry_t                 chain [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0] hits;
  logic                   accept;
  logic                   is_digit;
  logic                   too_long;
  logic                   any_hit;
  logic                   full;
  logic [3:0]             digit;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy && !halted;
  assign is_digit = (char_value inside {[CHAR_ZERO:CHAR_NINE]});
  assign too_long = (cur_len >= LEN_W'(MAX_DIGITS));
  assign digit    = 4'(char_value - CHAR_ZERO);
  assign any_hit  = |hits;
  assign full     = chain[MAX_ENTRIES-1].valid;
  assign chain[MAX_ENTRIES] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic prev_valid;
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = chain[i-1].valid;
    end
    dcoc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .key_in     (cur_key),
      .len_in     (cur_len),
      .prev_valid (prev_valid),
      .shift_in   (chain[i+1]),
      .entry      (chain[i]),
      .hit        (hits[i])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_CHAR && is_digit && !too_long && code_end) begin
            state_next = S_LOOKUP;
          end else if (opcode == OP_END && cur_len == '0 && chain[0].valid) begin
            state_next = S_DUMP;
          end
        end
      end
      S_LOOKUP: state_next = S_UPDATE;
      S_UPDATE: state_next = S_IDLE;
      S_DUMP: begin
        if (!chain[1].valid) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cur_key_next     = cur_key;
    cur_len_next     = cur_len;
    halted_next      = halted;
    valid_next       = 1'b0;
    kind_next        = KIND_INVALID;
    code_bcd_next    = '0;
    code_length_next = '0;
    occurrences_next = '0;
    last_result_next = 1'b1;
    ctrl.cmd         = CELL_HOLD;
    ctrl.any_hit     = any_hit;
    ctrl.full        = full;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_CHAR: begin
              if (!is_digit || too_long) begin
                valid_next  = 1'b1;
                halted_next = 1'b1;
              end else begin
                cur_key_next = {cur_key[KEY_W-5:0], digit};
                cur_len_next = cur_len + 1'b1;
              end
            end
            OP_EMPTY: begin
              valid_next  = 1'b1;
              halted_next = 1'b1;
            end
            OP_END: begin
              if (cur_len != '0) begin
                valid_next  = 1'b1;
                halted_next = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LOOKUP: begin
        ctrl.cmd = CELL_MATCH;
      end
      S_UPDATE: begin
        ctrl.cmd     = CELL_UPDATE;
        cur_key_next = '0;
        cur_len_next = '0;
        if (!any_hit && full) begin
          valid_next  = 1'b1;
          kind_next   = KIND_FULL;
          halted_next = 1'b1;
        end
      end
      S_DUMP: begin
        ctrl.cmd         = CELL_SHIFT;
        valid_next       = 1'b1;
        kind_next        = KIND_ENTRY;
        code_bcd_next    = chain[0].key;
        code_length_next = chain[0].len;
        occurrences_next = chain[0].count;
        last_result_next = !chain[1].valid;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cur_key <= '0;
      cur_len <= '0;
      halted  <= 1'b0;
      valid   <= 1'b0;
    end else begin
      state   <= state_next;
      cur_key <= cur_key_next;
      cur_len <= cur_len_next;
      halted  <= halted_next;
      valid   <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    kind        <= kind_next;
    code_bcd    <= code_bcd_next;
    code_length <= code_length_next;
    occurrences <= occurrences_next;
    last_result <= last_result_next;
  end

endmodule

`default_nettype wire
